[design/npps_pkg.sv]
// package for the nonpreemptive priority scheduler
// shared types and constants; no dependencies
`timescale 1ns / 1ps

package npps_pkg;

   localparam int NAME_W    = 8;
   localparam int LEVEL_W   = 3;
   localparam int TIME_W    = 11;
   localparam int SERVICE_W = 8;
   localparam int MAXQ_W    = 10;
   localparam int FRAC_BITS = 4;
   localparam int NOW_W     = TIME_W + FRAC_BITS;
   localparam int LEN_W     = SERVICE_W - FRAC_BITS + 1;

   localparam logic [LEVEL_W-1:0]   LEVEL_HIGHEST      = 3'd1;
   localparam logic [LEVEL_W-1:0]   LEVEL_LOWEST       = 3'd4;
   localparam logic [LEVEL_W-1:0]   LEVEL_NONE         = 3'd0;
   localparam logic [NAME_W-1:0]    IDLE_NAME          = 8'd45;
   localparam logic [MAXQ_W-1:0]    QUANTA_LIMIT_RESET = 10'd100;
   localparam logic [SERVICE_W-1:0] CEIL_ROUND         = 8'd15;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_RUN  = 1'b1;

   typedef struct packed {
      logic [NAME_W-1:0]    name;
      logic [LEVEL_W-1:0]   level;
      logic [TIME_W-1:0]    arrival;
      logic [SERVICE_W-1:0] service;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic sample;
      logic cand_done;
   } sel_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

[design/nonpreemptive_priority_scheduler.sv]
// load item: writes one table entry. run item: for each slot the whole table is scanned, then the slot is emitted
// requests are stalled while a run is in progress; an emit waits while a held result is stalled
// the scan uses the single read port of the process table and one shared comparator
// synchronous active-high reset: empty table, quanta limit = 100, no result pending
// depends on npps_pkg, npps_table, npps_select
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler #(
   parameter int MAX_PROCESSES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [npps_pkg::NAME_W-1:0]        req_proc_name,
   input  logic [npps_pkg::LEVEL_W-1:0]       req_priority_req,
   input  logic [npps_pkg::TIME_W-1:0]        req_arrival_fx,
   input  logic [npps_pkg::SERVICE_W-1:0]     req_service_fx,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_idle,
   output logic [npps_pkg::NAME_W-1:0]        rsp_out_name,
   output logic [npps_pkg::LEVEL_W-1:0]       rsp_out_priority,
   output logic [npps_pkg::TIME_W-1:0]        rsp_start_quantum,
   output logic [npps_pkg::TIME_W-1:0]        rsp_end_quantum,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [npps_pkg::MAXQ_W-1:0]        csr_quanta_limit
);

   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);

   npps_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [CNT_W-1:0]                 slot_ff, slot_in;
   logic [CNT_W-1:0]                 scan_ff, scan_in;
   logic [npps_pkg::TIME_W-1:0]      qc_ff, qc_in;
   logic [MAX_PROCESSES-1:0]         done_ff, done_in;
   logic [npps_pkg::MAXQ_W-1:0]      maxq_ff;
   logic                             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]                 rd_idx_ff, rd_idx_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             idle_ff, idle_in;
   logic [npps_pkg::NAME_W-1:0]      name_ff, name_in;
   logic [npps_pkg::LEVEL_W-1:0]     prio_ff, prio_in;
   logic [npps_pkg::TIME_W-1:0]      start_ff, start_in;
   logic [npps_pkg::TIME_W-1:0]      end_ff, end_in;
   logic                             last_ff, last_in;

   logic                             req_take;
   logic                             wr_en;
   npps_pkg::entry_type              wr_data;
   logic [npps_pkg::LEVEL_W-1:0]     level_sat;
   npps_pkg::entry_type              rd_data;
   npps_pkg::sel_ctl_type            sel_ctl;
   logic                             best_found;
   npps_pkg::entry_type              best_entry;
   logic [IDX_W-1:0]                 best_idx;
   logic [npps_pkg::NOW_W-1:0]       now_fx;
   logic [npps_pkg::SERVICE_W:0]     svc_round;
   logic [npps_pkg::LEN_W-1:0]       run_len;
   logic [npps_pkg::TIME_W-1:0]      slot_end;
   logic                             slot_last;
   logic                             out_free;

   npps_table #(
      .DEPTH (MAX_PROCESSES),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   npps_select #(
      .IDX_W (IDX_W)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sel_ctl),
      .cand       (rd_data),
      .cand_idx   (rd_idx_ff),
      .now_fx     (now_fx),
      .best_found (best_found),
      .best_entry (best_entry),
      .best_idx   (best_idx)
   );

   assign req_stall = (state_ff != npps_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign now_fx    = {qc_ff, {npps_pkg::FRAC_BITS{1'b0}}};
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // level saturates into 1..4
   always_comb begin
      priority if (req_priority_req < npps_pkg::LEVEL_HIGHEST) begin
         level_sat = npps_pkg::LEVEL_HIGHEST;
      end else if (req_priority_req > npps_pkg::LEVEL_LOWEST) begin
         level_sat = npps_pkg::LEVEL_LOWEST;
      end else begin
         level_sat = req_priority_req;
      end
      wr_data.name    = req_proc_name;
      wr_data.level   = level_sat;
      wr_data.arrival = req_arrival_fx;
      wr_data.service = req_service_fx;
      wr_en = req_take && (req_func == npps_pkg::FUNC_LOAD) && (count_ff < CNT_MAX);
   end

   // slot length is ceil(service) in whole quanta, or one quantum for an idle slot
   always_comb begin
      svc_round = {1'b0, best_entry.service} + {1'b0, npps_pkg::CEIL_ROUND};
      run_len   = svc_round[npps_pkg::SERVICE_W:npps_pkg::FRAC_BITS];
      if (best_found) begin
         slot_end = qc_ff + npps_pkg::TIME_W'(run_len);
      end else begin
         slot_end = qc_ff + npps_pkg::TIME_W'(1);
      end
      slot_last = (CNT_W'(slot_ff + 1'b1) == count_ff) ||
                  (slot_end >= {1'b0, maxq_ff});
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      scan_in      = scan_ff;
      qc_in        = qc_ff;
      done_in      = done_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = scan_ff[IDX_W-1:0];
      sel_ctl      = '0;
      sel_ctl.sample    = rd_vld_ff;
      sel_ctl.cand_done = done_ff[rd_idx_ff];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      idle_in      = idle_ff;
      name_in      = name_ff;
      prio_in      = prio_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      last_in      = last_ff;

      unique case (state_ff)
         npps_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_func == npps_pkg::FUNC_LOAD) begin
                  if (wr_en) begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  qc_in   = '0;
                  slot_in = '0;
                  scan_in = '0;
                  done_in = '0;
                  sel_ctl.clear = 1'b1;
                  if ((count_ff == '0) || (maxq_ff == '0)) begin
                     count_in = '0;
                  end else begin
                     state_in = npps_pkg::ST_SCAN;
                  end
               end
            end
         end
         npps_pkg::ST_SCAN: begin
            if (scan_ff < count_ff) begin
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               state_in = npps_pkg::ST_EMIT;
            end
         end
         npps_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               idle_in      = !best_found;
               name_in      = best_found ? best_entry.name : npps_pkg::IDLE_NAME;
               prio_in      = best_found ? best_entry.level : npps_pkg::LEVEL_NONE;
               start_in     = qc_ff;
               end_in       = slot_end;
               last_in      = slot_last;
               qc_in        = slot_end;
               slot_in      = slot_ff + 1'b1;
               if (best_found) begin
                  done_in[best_idx] = 1'b1;
               end
               if (slot_last) begin
                  count_in = '0;
                  state_in = npps_pkg::ST_IDLE;
               end else begin
                  scan_in       = '0;
                  sel_ctl.clear = 1'b1;
                  state_in      = npps_pkg::ST_SCAN;
               end
            end
         end
         default: begin
            state_in = npps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npps_pkg::ST_IDLE;
         count_ff     <= '0;
         slot_ff      <= '0;
         scan_ff      <= '0;
         qc_ff        <= '0;
         done_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         maxq_ff      <= npps_pkg::QUANTA_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         scan_ff      <= scan_in;
         qc_ff        <= qc_in;
         done_ff      <= done_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            maxq_ff <= csr_quanta_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      idle_ff   <= idle_in;
      name_ff   <= name_in;
      prio_ff   <= prio_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_idle          = idle_ff;
   assign rsp_out_name      = name_ff;
   assign rsp_out_priority  = prio_ff;
   assign rsp_start_quantum = start_ff;
   assign rsp_end_quantum   = end_ff;
   assign rsp_last          = last_ff;

endmodule

[design/npps_table.sv]
// process table: one write port, one registered read port
// depends on npps_pkg
`timescale 1ns / 1ps

module npps_table #(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  npps_pkg::entry_type wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output npps_pkg::entry_type rd_data
);

   npps_pkg::entry_type mem [DEPTH];
   npps_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/npps_select.sv]
// shared compare unit: keeps the best ready candidate seen during a table scan
// depends on npps_pkg
`timescale 1ns / 1ps

module npps_select #(
   parameter int IDX_W = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  npps_pkg::sel_ctl_type         ctl,
   input  npps_pkg::entry_type           cand,
   input  logic [IDX_W-1:0]              cand_idx,
   input  logic [npps_pkg::NOW_W-1:0]    now_fx,
   output logic                          best_found,
   output npps_pkg::entry_type           best_entry,
   output logic [IDX_W-1:0]              best_idx
);

   logic                found_ff, found_in;
   npps_pkg::entry_type entry_ff, entry_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                ready_cand;
   logic                better;

   always_comb begin
      ready_cand = !ctl.cand_done &&
                   ({{npps_pkg::FRAC_BITS{1'b0}}, cand.arrival} <= now_fx);
      // strict compares keep the earlier table entry on ties
      better = !found_ff || (cand.level < entry_ff.level) ||
               ((cand.level == entry_ff.level) && (cand.arrival < entry_ff.arrival));
      found_in = found_ff;
      entry_in = entry_ff;
      idx_in   = idx_ff;
      priority if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample && ready_cand && better) begin
         found_in = 1'b1;
         entry_in = cand;
         idx_in   = cand_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      idx_ff   <= idx_in;
   end

   assign best_found = found_ff;
   assign best_entry = entry_ff;
   assign best_idx   = idx_ff;

endmodule
